// ===== src/tssd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tssd_pkg
// Constants and the CRC-8 byte update for the sensor scratchpad decoder.
// ----------------------------------------------------------------------------
package tssd_pkg;

	localparam int unsigned SCRATCH_LEN = 9;   // bytes per scratchpad frame
	localparam int unsigned CRC_LEN     = 8;   // bytes covered by the CRC
	localparam int unsigned COUNT_W     = 4;   // width of the byte index

	localparam logic [COUNT_W-1:0] IDX_TEMP_LO = COUNT_W'(0);
	localparam logic [COUNT_W-1:0] IDX_TEMP_HI = COUNT_W'(1);
	localparam logic [COUNT_W-1:0] IDX_CONFIG  = COUNT_W'(4);
	localparam logic [COUNT_W-1:0] IDX_CRC     = COUNT_W'(CRC_LEN);

	localparam logic [7:0] CRC_POLY_REFL = 8'h8C;  // 0x31 bit-reversed
	localparam logic [3:0] RES_BASE      = 4'd9;
	localparam int         TEMP_SCALE    = 100;
	localparam int unsigned FRAC_BITS    = 4;     // sixteenths

	// One byte through the reflected CRC-8, eight narrow shift/xor steps.
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY_REFL;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== src/temp_sensor_scratchpad_decoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// temp_sensor_scratchpad_decoder
// Decodes the nine-byte temperature sensor scratchpad into one result.
// ----------------------------------------------------------------------------
// Takes one scratchpad request per cycle when not stalled, byte 0 first. Each
// byte is held in an input register, where the running CRC-8 (reflected, poly
// 0x31, init 0) is advanced and bytes 0, 1 and bits 6:5 of byte 4 are kept.
// The ninth byte is checked against the CRC and a single result is loaded
// into the output register: raw temperature in sixteenths, the same in
// hundredths (truncated toward zero), resolution 9..12 and crc_valid.
// frame_start forces the byte to be byte 0 and drops any partial frame;
// after byte 8 the next byte starts a new frame regardless.
// Rate: one byte per cycle unless a result is held; byte 8 moves via the input
// and result registers to out_valid. The only back-pressure is a held output
// result: the input register then waits; in_stall rises once it is full too.
// ----------------------------------------------------------------------------
module temp_sensor_scratchpad_decoder
	import tssd_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	// byte channel
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [7:0]         byte_value,
	input  wire logic               frame_start,
	// result channel
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [15:0]      temp_sixteenths,
	output logic signed [18:0]      temp_hundredths,
	output logic [3:0]              resolution,
	output logic                    crc_valid
);

	// input register
	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic               start_s1;

	// frame state
	logic [COUNT_W-1:0] count_q;
	logic [7:0]         crc_q;
	logic [7:0]         temp_lo_q;
	logic [7:0]         temp_hi_q;
	logic [1:0]         res_code_q;

	// result register
	logic               valid_s2;
	logic signed [15:0] sixteenths_s2;
	logic signed [18:0] hundredths_s2;
	logic [3:0]         resolution_s2;
	logic               crc_ok_s2;

	logic               out_busy;
	logic               advance_s1;
	logic [COUNT_W-1:0] idx;
	logic [7:0]         crc_base;
	logic [7:0]         crc_next;
	logic               last_byte;
	logic signed [15:0] raw;
	logic signed [22:0] raw_ext;
	logic signed [22:0] prod;
	logic signed [22:0] biased;
	logic signed [22:0] scaled;

	// output register held while the far side stalls
	assign out_busy   = valid_s2 && out_stall;
	assign advance_s1 = valid_s1 && !out_busy;
	assign in_stall   = valid_s1 && out_busy;

	// byte index: restart or out-of-range count means byte 0
	always_comb begin
		if (start_s1 || (count_q >= COUNT_W'(SCRATCH_LEN))) begin
			idx = IDX_TEMP_LO;
		end else begin
			idx = count_q;
		end
	end

	assign crc_base  = (idx == IDX_TEMP_LO) ? 8'h00 : crc_q;
	assign crc_next  = crc8_byte(crc_base, byte_s1);
	assign last_byte = (idx == IDX_CRC);

	// hundredths = raw * 100 / 16, rounded toward zero: bias negatives by 15
	assign raw     = $signed({temp_hi_q, temp_lo_q});
	assign raw_ext = 23'(raw);
	assign prod    = raw_ext * 23'(TEMP_SCALE);
	assign biased  = prod + (prod[22] ? 23'((1 << FRAC_BITS) - 1) : 23'sd0);
	assign scaled  = biased >>> FRAC_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1  <= byte_value;
			start_s1 <= frame_start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			crc_q   <= '0;
		end else if (advance_s1) begin
			if (last_byte) begin
				count_q <= '0;
			end else begin
				count_q <= idx + COUNT_W'(1);
				crc_q   <= crc_next;
			end
		end
	end

	// stored fields, always written before byte 8 is reached
	always_ff @(posedge clk) begin
		if (advance_s1) begin
			case (idx)
				IDX_TEMP_LO: temp_lo_q  <= byte_s1;
				IDX_TEMP_HI: temp_hi_q  <= byte_s1;
				IDX_CONFIG:  res_code_q <= byte_s1[6:5];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!out_busy) begin
			valid_s2 <= advance_s1 && last_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && last_byte) begin
			sixteenths_s2 <= raw;
			hundredths_s2 <= scaled[18:0];
			resolution_s2 <= RES_BASE + {2'b00, res_code_q};
			crc_ok_s2     <= (crc_q == byte_s1);
		end
	end

	assign out_valid       = valid_s2;
	assign temp_sixteenths = sixteenths_s2;
	assign temp_hundredths = hundredths_s2;
	assign resolution      = resolution_s2;
	assign crc_valid       = crc_ok_s2;

endmodule
`default_nettype wire

// ===== tb/sv/temp_sensor_scratchpad_decoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temp_sensor_scratchpad_decoder_tb
// Self-checking bench for the scratchpad decoder: byte requests in, readings out.
// ----------------------------------------------------------------------------
// Scratchpad bytes are sent as requests on the input channel. An internal
// decoder of our own follows every accepted byte: it keeps the frame index,
// the running CRC-8 and the kept bytes. After each ninth byte it queues the
// reading it expects. Each reading taken from the block is checked field by
// field against the oldest queued reading. Both channels idle and stall at
// random, apart from one back-to-back stretch.
// ----------------------------------------------------------------------------
module temp_sensor_scratchpad_decoder_tb
	import tssd_pkg::*;
();

	// One decoded reading, as the result channel carries it
	typedef struct packed {
		logic signed [15:0] sixteenths;
		logic signed [18:0] hundredths;
		logic [3:0]         res_bits;
		logic               crc_ok;
	} reading_t;

	logic                clk         = 1'b0;
	logic                arst_n      = 1'b0;
	logic                in_valid    = 1'b0;
	logic                in_stall;
	logic [7:0]          byte_value  = 8'h00;
	logic                frame_start = 1'b0;
	logic                out_valid;
	logic                out_stall   = 1'b0;
	logic signed [15:0]  temp_sixteenths;
	logic signed [18:0]  temp_hundredths;
	logic [3:0]          resolution;
	logic                crc_valid;

	// Decoder state, mirrors the block's frame tracking
	logic [COUNT_W-1:0]  scratch_idx = '0;
	logic [7:0]          crc_run     = 8'h00;
	logic [7:0]          lo_keep     = 8'h00;
	logic [7:0]          hi_keep     = 8'h00;
	logic [1:0]          res_keep    = 2'b00;

	reading_t            pending_readings[$];
	logic [7:0]          frame_body[0:7];
	logic                burst_mode  = 1'b0;   // no idling on either side
	int                  items_sent  = 0;
	int                  error_count = 0;

	temp_sensor_scratchpad_decoder DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.byte_value      (byte_value),
		.frame_start     (frame_start),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.temp_sixteenths (temp_sixteenths),
		.temp_hundredths (temp_hundredths),
		.resolution      (resolution),
		.crc_valid       (crc_valid)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Generous ceiling on the run time of the slowest legal run
	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	// Bit-serial form of the reflected CRC-8: feed data LSB first, shift right
	function automatic logic [7:0] crc8_maxim_next(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		logic       fb;
		c = crc;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ b[i];
			c  = {1'b0, c[7:1]} ^ (fb ? CRC_POLY_REFL : 8'h00);
		end
		return c;
	endfunction

	// Advance the decoder by one accepted byte; queue a reading on the CRC byte
	function automatic void decode_scratch_byte(input logic [7:0] b, input logic fs);
		logic [COUNT_W-1:0] idx;
		reading_t           r;
		int                 raw;
		int                 hund;
		idx = scratch_idx;
		// frame_start, or a count past the frame, means byte 0
		if (fs || idx >= SCRATCH_LEN) begin
			idx = IDX_TEMP_LO;
		end
		if (idx == IDX_TEMP_LO) begin
			crc_run = 8'h00;
		end
		if (idx < CRC_LEN) begin
			crc_run = crc8_maxim_next(crc_run, b);
			case (idx)
				IDX_TEMP_LO: begin
					lo_keep = b;
				end
				IDX_TEMP_HI: begin
					hi_keep = b;
				end
				IDX_CONFIG: begin
					res_keep = b[6:5];
				end
				default: begin
				end
			endcase
			scratch_idx = idx + 1'b1;
		end else begin
			raw  = int'(signed'({hi_keep, lo_keep}));
			// int division truncates toward zero, as required
			hund = (raw * TEMP_SCALE) / int'(1 << FRAC_BITS);
			r.sixteenths = raw[15:0];
			r.hundredths = hund[18:0];
			r.res_bits   = RES_BASE + {2'b00, res_keep};
			r.crc_ok     = (crc_run == b);
			pending_readings.push_back(r);
			scratch_idx  = '0;   // next byte opens a new frame
		end
	endfunction

	// Send one byte request; valid stays up afterwards unless the next call idles
	task automatic push_scratch_byte(input logic [7:0] b, input logic fs);
		while (!burst_mode && $urandom_range(0, 99) < 23) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		byte_value  <= b;
		frame_start <= fs;
		do @(posedge clk); while (in_stall);
		decode_scratch_byte(b, fs);
		items_sent++;
	endtask

	// Random frame body: temperature drawn from a few shapes, other bytes free
	task automatic fill_random_body();
		logic [15:0] temp;
		int          t;
		case ($urandom_range(0, 3))
			0: begin
				temp = 16'($urandom_range(0, 65535));
			end
			1: begin
				// small magnitudes, negatives included: truncation toward zero
				t    = $urandom_range(0, 127) - 64;
				temp = t[15:0];
			end
			2: begin
				case ($urandom_range(0, 3))
					0: temp = 16'h8000;
					1: temp = 16'h7FFF;
					2: temp = 16'hFFFF;
					default: temp = 16'h0000;
				endcase
			end
			default: begin
				// usual sensor range, -55 to +125 degrees
				t    = $urandom_range(0, 180 * 16) - 55 * 16;
				temp = t[15:0];
			end
		endcase
		frame_body[0] = temp[7:0];
		frame_body[1] = temp[15:8];
		for (int i = 2; i < 8; i++) begin
			frame_body[i] = 8'($urandom);
		end
	endtask

	// Send the first n_bytes of the frame: body bytes, then the CRC byte (good or corrupted)
	task automatic send_frame(input int n_bytes, input logic fs_first, input logic crc_good);
		logic [7:0] crc;
		crc = 8'h00;
		for (int i = 0; i < 8; i++) begin
			crc = crc8_maxim_next(crc, frame_body[i]);
		end
		for (int i = 0; i < n_bytes; i++) begin
			if (i < 8) begin
				push_scratch_byte(frame_body[i], (i == 0) ? fs_first : 1'b0);
			end else begin
				push_scratch_byte(crc_good ? crc : crc ^ 8'($urandom_range(1, 255)), 1'b0);
			end
		end
	endtask

	// Most negative temperature, top resolution code, all-ones and zero bytes
	task automatic test_extremes();
		frame_body = '{8'h00, 8'h80, 8'hFF, 8'h00, 8'h60, 8'hFF, 8'h0C, 8'h10};
		send_frame(SCRATCH_LEN, 1'b1, 1'b1);
	endtask

	// Bytes after a reading start a new frame unasked; frame_start then drops it
	task automatic test_restart();
		push_scratch_byte(8'hFF, 1'b0);
		push_scratch_byte(8'h7F, 1'b0);
		push_scratch_byte(8'h55, 1'b0);
		// -1/16 degree, resolution code 0 with the other bits set, bad CRC
		frame_body = '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'h9F, 8'hFF, 8'h0C, 8'h10};
		send_frame(SCRATCH_LEN, 1'b1, 1'b0);
	endtask

	// Long stretch with both channels running flat out
	task automatic test_back_to_back();
		burst_mode <= 1'b1;
		for (int f = 0; f < 30; f++) begin
			fill_random_body();
			send_frame(SCRATCH_LEN, 1'b1, $urandom_range(0, 3) != 0);
		end
		burst_mode <= 1'b0;
	endtask

	// Sender holds off until every reading is back, then carries on
	task automatic test_drain_pause();
		for (int f = 0; f < 3; f++) begin
			fill_random_body();
			send_frame(SCRATCH_LEN, 1'b1, 1'b1);
		end
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_readings.size() != 0);
		for (int f = 0; f < 2; f++) begin
			fill_random_body();
			send_frame(SCRATCH_LEN, 1'b1, 1'b0);
		end
	endtask

	// Mostly whole frames; some cut short and restarted, some loose noise bytes
	task automatic test_random_frames(input int item_target);
		int roll;
		int n_noise;
		while (items_sent < item_target) begin
			roll = $urandom_range(0, 99);
			fill_random_body();
			if (roll < 75) begin
				send_frame(SCRATCH_LEN, $urandom_range(0, 99) >= 15, $urandom_range(0, 3) != 0);
			end else if (roll < 88) begin
				send_frame($urandom_range(1, 8), 1'b1, 1'b1);
			end else begin
				n_noise = $urandom_range(1, 5);
				for (int i = 0; i < n_noise; i++) begin
					push_scratch_byte(8'($urandom), $urandom_range(0, 3) == 0);
				end
			end
		end
	endtask

	// Result side: check each taken reading, then pick the next stall
	always @(posedge clk) begin : reading_check
		reading_t want;
		reading_t got;
		if (arst_n && out_valid && !out_stall) begin
			got = '{temp_sixteenths, temp_hundredths, resolution, crc_valid};
			if (pending_readings.size() == 0) begin
				if (error_count < 10) begin
					$display("%0t: unexpected reading t16=%0d t100=%0d res=%0d crc=%0b",
						$time, got.sixteenths, got.hundredths, got.res_bits, got.crc_ok);
				end
				error_count++;
			end else begin
				want = pending_readings.pop_front();
				if (got !== want) begin
					if (error_count < 10) begin
						$display("%0t: reading mismatch exp t16=%0d t100=%0d res=%0d crc=%0b",
							$time, want.sixteenths, want.hundredths, want.res_bits,
							want.crc_ok);
						$display("%0t:                  got t16=%0d t100=%0d res=%0d crc=%0b",
							$time, got.sixteenths, got.hundredths, got.res_bits,
							got.crc_ok);
					end
					error_count++;
				end
			end
		end
		out_stall <= !burst_mode && ($urandom_range(0, 99) < 23);
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_extremes();
		test_restart();
		test_back_to_back();
		test_drain_pause();
		test_random_frames(1900);

		// all requests in; wait for the last readings, then keep watching for stragglers
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_readings.size() != 0);
		repeat (8) @(posedge clk);

		if (error_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
src/tssd_pkg.sv
src/temp_sensor_scratchpad_decoder.sv
tb/sv/temp_sensor_scratchpad_decoder_tb.sv
